// ----- sv/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg
// Shared widths, constants and types of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  // width of the echo tick counter
  localparam int unsigned COUNT_WIDTH = 8;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam int unsigned SCALE_W = 8;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd85;

  // count times scale
  localparam int unsigned PROD_W = COUNT_WIDTH + SCALE_W;

  // exact floor(x / 100) for x below 2**PROD_W via reciprocal multiply
  localparam int unsigned DIV_SHIFT = PROD_W + 7;
  localparam int unsigned RECIP_W   = PROD_W + 1;
  localparam int unsigned FULL_W    = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'((64'd1 << DIV_SHIFT) / 64'd100 + 64'd1);

  // quotient is below 2**PROD_W / 64
  localparam int unsigned QUOT_W = FULL_W - DIV_SHIFT;

  localparam int unsigned DIST_W = 10;
  localparam logic [DIST_W-1:0] DIST_LIMIT = 10'd999;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned REM_W   = 7;
  localparam int unsigned CHAR_W  = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [ADDR_W-1:0] REG_SCALE_ADDR = 3'd0;

  // measurement handed from the pulse counter to the converter
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic                   sat;
  } meas_t;

endpackage

`default_nettype wire

// ----- sv/ultrasonic_echo_ranger_unit.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Echo pulse width rangefinder with ASCII distance digits.
// ----------------------------------------------------------------------------
// One echo sample is taken per cycle while nothing downstream is backed up.
// The block waits for the echo to rise, counts high samples (saturating at
// the counter maximum, which sets count_saturated), and when the echo falls
// it delivers one result: floor(count * scale / 100) centimetres, clamped to
// 999, with its hundreds, tens and ones digits in ASCII. After the falling
// sample the result passes the measurement register and then the product,
// reciprocal divide, hundreds split and digit stages to the output. Register
// scale_hundredths_cm sits at byte address 0 and resets to 85.
`default_nettype none

module ultrasonic_echo_ranger_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // echo sample channel
  input  wire logic                        echo_valid_i,
  output logic                             echo_stall_o,
  input  wire logic                        echo_level_i,
  // result channel
  output logic                             res_valid_o,
  input  wire logic                        res_stall_i,
  output logic [uer_pkg::DIST_W-1:0]       distance_cm_o,
  output logic [uer_pkg::CHAR_W-1:0]       hundreds_char_o,
  output logic [uer_pkg::CHAR_W-1:0]       tens_char_o,
  output logic [uer_pkg::CHAR_W-1:0]       ones_char_o,
  output logic                             count_saturated_o,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [uer_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [uer_pkg::DATA_W-1:0]  pwdata,
  output logic [uer_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  logic [uer_pkg::SCALE_W-1:0] scale_q, scale_d;
  logic                        cfg_wr;
  logic                        meas_valid;
  logic                        meas_ready;
  uer_pkg::meas_t              meas;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    scale_d = scale_q;
    if (cfg_wr && paddr == uer_pkg::REG_SCALE_ADDR) begin
      scale_d = pwdata[uer_pkg::SCALE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= uer_pkg::SCALE_RESET;
    end else begin
      scale_q <= scale_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == uer_pkg::REG_SCALE_ADDR) begin
      prdata = uer_pkg::DATA_W'(scale_q);
    end
  end

  uer_pulse u_pulse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .echo_valid_i (echo_valid_i),
    .echo_stall_o (echo_stall_o),
    .echo_level_i (echo_level_i),
    .meas_valid_o (meas_valid),
    .meas_ready_i (meas_ready),
    .meas_o       (meas)
  );

  uer_convert u_convert (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .meas_valid_i      (meas_valid),
    .meas_ready_o      (meas_ready),
    .meas_i            (meas),
    .scale_i           (scale_q),
    .res_valid_o       (res_valid_o),
    .res_stall_i       (res_stall_i),
    .distance_cm_o     (distance_cm_o),
    .hundreds_char_o   (hundreds_char_o),
    .tens_char_o       (tens_char_o),
    .ones_char_o       (ones_char_o),
    .count_saturated_o (count_saturated_o)
  );

endmodule

`default_nettype wire

// ----- sv/uer_pulse.sv -----
// ----------------------------------------------------------------------------
// uer_pulse
// Echo pulse width counter: waits for the rise, counts high samples and
// hands the finished measurement on when the echo falls.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_pulse (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          echo_valid_i,
  output logic               echo_stall_o,
  input  wire logic          echo_level_i,
  output logic               meas_valid_o,
  input  wire logic          meas_ready_i,
  output uer_pkg::meas_t     meas_o
);

  logic                            measuring_q, measuring_d;
  logic [uer_pkg::COUNT_WIDTH-1:0] count_q, count_d;
  logic                            sat_q, sat_d;
  logic                            meas_valid_q, meas_valid_d;
  uer_pkg::meas_t                  meas_q, meas_d;
  logic                            accept;
  logic                            finish;
  logic [uer_pkg::COUNT_WIDTH-1:0] count_inc;

  assign echo_stall_o = meas_valid_q & ~meas_ready_i;
  assign accept       = echo_valid_i & ~echo_stall_o;
  assign finish       = accept & measuring_q & ~echo_level_i;
  assign count_inc    = count_q + uer_pkg::COUNT_WIDTH'(1);

  always_comb begin
    measuring_d = measuring_q;
    count_d     = count_q;
    sat_d       = sat_q;
    if (accept) begin
      if (!measuring_q) begin
        if (echo_level_i) begin
          // rising sample is the first tick
          measuring_d = 1'b1;
          count_d     = uer_pkg::COUNT_WIDTH'(1);
          sat_d       = 1'b0;
        end
      end else if (echo_level_i) begin
        if (count_q != uer_pkg::COUNT_MAX) begin
          count_d = count_inc;
        end
        sat_d = sat_q | (count_inc == uer_pkg::COUNT_MAX) |
                (count_q == uer_pkg::COUNT_MAX);
      end else begin
        measuring_d = 1'b0;
        count_d     = '0;
        sat_d       = 1'b0;
      end
    end
  end

  always_comb begin
    meas_valid_d = meas_valid_q;
    meas_d       = meas_q;
    if (finish) begin
      meas_valid_d = 1'b1;
      meas_d.count = count_q;
      meas_d.sat   = sat_q;
    end else if (meas_ready_i) begin
      meas_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      measuring_q  <= 1'b0;
      count_q      <= '0;
      sat_q        <= 1'b0;
      meas_valid_q <= 1'b0;
    end else begin
      measuring_q  <= measuring_d;
      count_q      <= count_d;
      sat_q        <= sat_d;
      meas_valid_q <= meas_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meas_q <= meas_d;
  end

  assign meas_valid_o = meas_valid_q;
  assign meas_o       = meas_q;

endmodule

`default_nettype wire

// ----- sv/uer_convert.sv -----
// ----------------------------------------------------------------------------
// uer_convert
// Pipelined conversion of a tick count to centimetres and three ASCII digits.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_convert (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        meas_valid_i,
  output logic                             meas_ready_o,
  input  wire uer_pkg::meas_t              meas_i,
  input  wire logic [uer_pkg::SCALE_W-1:0] scale_i,
  output logic                             res_valid_o,
  input  wire logic                        res_stall_i,
  output logic [uer_pkg::DIST_W-1:0]       distance_cm_o,
  output logic [uer_pkg::CHAR_W-1:0]       hundreds_char_o,
  output logic [uer_pkg::CHAR_W-1:0]       tens_char_o,
  output logic [uer_pkg::CHAR_W-1:0]       ones_char_o,
  output logic                             count_saturated_o
);

  // stage valids: product, quotient, hundreds split, output
  logic prod_v_q, quot_v_q, split_v_q, out_v_q;
  logic prod_rdy, quot_rdy, split_rdy, out_rdy;

  logic [uer_pkg::PROD_W-1:0]  prod_q;
  logic                        prod_sat_q;
  logic [uer_pkg::QUOT_W-1:0]  quot_q;
  logic                        quot_sat_q;
  logic [uer_pkg::DIST_W-1:0]  dist_q;
  logic [uer_pkg::DIGIT_W-1:0] hund_q;
  logic [uer_pkg::REM_W-1:0]   rem_q;
  logic                        split_sat_q;

  logic [uer_pkg::PROD_W-1:0]  prod_d;
  logic [uer_pkg::FULL_W-1:0]  full_prod;
  logic [uer_pkg::DIST_W-1:0]  dist_d;
  logic [15:0]                 hund_full;
  logic [uer_pkg::DIGIT_W-1:0] hund_d;
  logic [uer_pkg::DIST_W-1:0]  hund_x100;
  logic [uer_pkg::REM_W-1:0]   rem_d;
  logic [14:0]                 tens_full;
  logic [uer_pkg::DIGIT_W-1:0] tens_d;
  logic [uer_pkg::REM_W-1:0]   tens_x10;
  logic [uer_pkg::DIGIT_W-1:0] ones_d;

  assign out_rdy      = ~out_v_q | ~res_stall_i;
  assign split_rdy    = ~split_v_q | out_rdy;
  assign quot_rdy     = ~quot_v_q | split_rdy;
  assign prod_rdy     = ~prod_v_q | quot_rdy;
  assign meas_ready_o = prod_rdy;

  assign prod_d = uer_pkg::PROD_W'(meas_i.count) * uer_pkg::PROD_W'(scale_i);

  assign full_prod = uer_pkg::FULL_W'(prod_q) * uer_pkg::FULL_W'(uer_pkg::DIV_RECIP);

  always_comb begin
    if (quot_q > uer_pkg::QUOT_W'(uer_pkg::DIST_LIMIT)) begin
      dist_d = uer_pkg::DIST_LIMIT;
    end else begin
      dist_d = quot_q[uer_pkg::DIST_W-1:0];
    end
    // d / 100 as (d * 41) >> 12, exact below 1000
    hund_full = 16'(dist_d) * 16'd41;
    hund_d    = hund_full[15:12];
    hund_x100 = uer_pkg::DIST_W'(hund_d) * 10'd100;
    rem_d     = uer_pkg::REM_W'(dist_d - hund_x100);
  end

  always_comb begin
    // r / 10 as (r * 205) >> 11, exact below 100
    tens_full = 15'(rem_q) * 15'd205;
    tens_d    = tens_full[14:11];
    tens_x10  = uer_pkg::REM_W'(tens_d) * 7'd10;
    ones_d    = uer_pkg::DIGIT_W'(rem_q - tens_x10);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q  <= 1'b0;
      quot_v_q  <= 1'b0;
      split_v_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (prod_rdy)  prod_v_q  <= meas_valid_i;
      if (quot_rdy)  quot_v_q  <= prod_v_q;
      if (split_rdy) split_v_q <= quot_v_q;
      if (out_rdy)   out_v_q   <= split_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_rdy) begin
      prod_q     <= prod_d;
      prod_sat_q <= meas_i.sat;
    end
    if (quot_rdy) begin
      quot_q     <= full_prod[uer_pkg::DIV_SHIFT +: uer_pkg::QUOT_W];
      quot_sat_q <= prod_sat_q;
    end
    if (split_rdy) begin
      dist_q      <= dist_d;
      hund_q      <= hund_d;
      rem_q       <= rem_d;
      split_sat_q <= quot_sat_q;
    end
    if (out_rdy) begin
      distance_cm_o     <= dist_q;
      hundreds_char_o   <= uer_pkg::ASCII_ZERO + uer_pkg::CHAR_W'(hund_q);
      tens_char_o       <= uer_pkg::ASCII_ZERO + uer_pkg::CHAR_W'(tens_d);
      ones_char_o       <= uer_pkg::ASCII_ZERO + uer_pkg::CHAR_W'(ones_d);
      count_saturated_o <= split_sat_q;
    end
  end

  assign res_valid_o = out_v_q;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ultrasonic echo ranger unit.
// ----------------------------------------------------------------------------
// Echo samples are sent one transaction at a time. A scoreboard class tracks
// the pulse counter and the scale register, and predicts each distance with
// its ASCII digits and saturation flag. Every result transaction is compared
// field by field with the oldest prediction. A short directed part covers
// the edge cases, then random pulse trains run under several scale settings.
// The echo channel idles and the result channel stalls at random.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [uer_pkg::DIST_W-1:0] distance;
    logic [uer_pkg::CHAR_W-1:0] hundreds;
    logic [uer_pkg::CHAR_W-1:0] tens;
    logic [uer_pkg::CHAR_W-1:0] ones;
    logic                       sat;
  } range_t;

  localparam int unsigned TICK_MAX     = 2**uer_pkg::COUNT_WIDTH - 1;
  localparam logic [uer_pkg::ADDR_W-1:0] SPARE_ADDR = 3'd4;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 720;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned MIN_RANGES   = 16;
  localparam int unsigned MAX_REPORTS  = 10;

  class range_scoreboard;
    logic [uer_pkg::SCALE_W-1:0]     scale;
    bit                              measuring;
    logic [uer_pkg::COUNT_WIDTH-1:0] ticks;
    bit                              sat;
    range_t                          expected_ranges[$];
    int unsigned                     mismatches;
    int unsigned                     samples;
    int unsigned                     predicted;
    int unsigned                     checked;

    function new();
      scale      = uer_pkg::SCALE_RESET;
      measuring  = 1'b0;
      ticks      = '0;
      sat        = 1'b0;
      mismatches = 0;
      samples    = 0;
      predicted  = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [uer_pkg::ADDR_W-1:0] addr,
                            logic [uer_pkg::DATA_W-1:0] data);
      if (addr == uer_pkg::REG_SCALE_ADDR) begin
        scale = data[uer_pkg::SCALE_W-1:0];
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] error: %s", $time, msg);
      end
    endfunction

    function void add_tick();
      if (ticks < uer_pkg::COUNT_MAX) begin
        ticks++;
      end
      if (ticks == uer_pkg::COUNT_MAX) begin
        sat = 1'b1;
      end
    endfunction

    function void note_echo_sample(logic level);
      int unsigned cm;
      range_t      r;
      samples++;
      if (!measuring) begin
        if (level) begin
          measuring = 1'b1;
          ticks     = '0;
          sat       = 1'b0;
          add_tick();
        end
      end else if (level) begin
        add_tick();
      end else begin
        // falling edge closes the pulse
        cm = (32'(ticks) * 32'(scale)) / 100;
        if (cm > uer_pkg::DIST_LIMIT) begin
          cm = uer_pkg::DIST_LIMIT;
        end
        r.distance = uer_pkg::DIST_W'(cm);
        r.hundreds = uer_pkg::ASCII_ZERO + uer_pkg::CHAR_W'(cm / 100);
        r.tens     = uer_pkg::ASCII_ZERO + uer_pkg::CHAR_W'((cm % 100) / 10);
        r.ones     = uer_pkg::ASCII_ZERO + uer_pkg::CHAR_W'(cm % 10);
        r.sat      = sat;
        expected_ranges.push_back(r);
        predicted++;
        measuring = 1'b0;
        ticks     = '0;
        sat       = 1'b0;
      end
    endfunction

    function void check_range(range_t got);
      range_t want;
      checked++;
      if (expected_ranges.size() == 0) begin
        flag($sformatf("result transaction with nothing pending: distance %0d",
                       got.distance));
      end else begin
        want = expected_ranges.pop_front();
        if (got.distance !== want.distance)
          flag($sformatf("distance_cm expected %0d got %0d", want.distance, got.distance));
        if (got.hundreds !== want.hundreds)
          flag($sformatf("hundreds_char expected %0d got %0d", want.hundreds, got.hundreds));
        if (got.tens !== want.tens)
          flag($sformatf("tens_char expected %0d got %0d", want.tens, got.tens));
        if (got.ones !== want.ones)
          flag($sformatf("ones_char expected %0d got %0d", want.ones, got.ones));
        if (got.sat !== want.sat)
          flag($sformatf("count_saturated expected %0d got %0d", want.sat, got.sat));
      end
    endfunction

    function void check_scale_readback(logic [uer_pkg::DATA_W-1:0] got);
      if (got !== uer_pkg::DATA_W'(scale))
        flag($sformatf("scale readback expected %0d got %0d", scale, got));
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       echo_valid_i = 1'b0;
  logic                       echo_stall_o;
  logic                       echo_level_i = 1'b0;
  logic                       res_valid_o;
  logic                       res_stall_i = 1'b0;
  logic [uer_pkg::DIST_W-1:0] distance_cm_o;
  logic [uer_pkg::CHAR_W-1:0] hundreds_char_o;
  logic [uer_pkg::CHAR_W-1:0] tens_char_o;
  logic [uer_pkg::CHAR_W-1:0] ones_char_o;
  logic                       count_saturated_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [uer_pkg::ADDR_W-1:0] paddr = '0;
  logic [uer_pkg::DATA_W-1:0] pwdata = '0;
  logic [uer_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  range_scoreboard ledger;
  bit              quiet = 1'b0;
  int unsigned     stall_left = 0;
  int unsigned     stall_roll;
  int unsigned     settings_seen = 0;

  ultrasonic_echo_ranger_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .echo_valid_i      (echo_valid_i),
    .echo_stall_o      (echo_stall_o),
    .echo_level_i      (echo_level_i),
    .res_valid_o       (res_valid_o),
    .res_stall_i       (res_stall_i),
    .distance_cm_o     (distance_cm_o),
    .hundreds_char_o   (hundreds_char_o),
    .tens_char_o       (tens_char_o),
    .ones_char_o       (ones_char_o),
    .count_saturated_o (count_saturated_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side backpressure: mostly short stalls, now and then a long one
  always @(posedge clk_i) begin
    if (quiet) begin
      res_stall_i <= 1'b0;
      stall_left  = 0;
    end else if (stall_left != 0) begin
      res_stall_i <= 1'b1;
      stall_left--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        res_stall_i <= 1'b0;
      end else begin
        res_stall_i <= 1'b1;
        stall_left = (stall_roll < 96) ? $urandom_range(0, 2) : $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) begin
      ledger.check_range('{distance: distance_cm_o, hundreds: hundreds_char_o,
                           tens: tens_char_o, ones: ones_char_o,
                           sat: count_saturated_o});
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 10);
    else return $urandom_range(11, 40);
  endfunction

  function automatic int unsigned pick_width();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 94) return $urandom_range(1, 24);
    else if (roll < 97) return $urandom_range(TICK_MAX - 1, TICK_MAX + 1);
    else return $urandom_range(TICK_MAX + 2, TICK_MAX + 45);
  endfunction

  task automatic send_sample(logic level);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      echo_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    echo_valid_i <= 1'b1;
    echo_level_i <= level;
    do @(posedge clk_i); while (echo_stall_o);
    ledger.note_echo_sample(level);
  endtask

  // a high stretch of the given width, then the falling sample and extra lows
  task automatic send_pulse(int unsigned width, int unsigned rest);
    repeat (width) send_sample(1'b1);
    repeat (rest + 1) send_sample(1'b0);
  endtask

  task automatic apb_write(logic [uer_pkg::ADDR_W-1:0] addr,
                           logic [uer_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ledger.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    // leave the bus idle before the next transfer
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(logic [uer_pkg::ADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ledger.check_scale_readback(prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait for every pending distance, then let the pipeline empty out
  task automatic settle();
    echo_valid_i <= 1'b0;
    while (ledger.expected_ranges.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_scale(logic [uer_pkg::DATA_W-1:0] value);
    settle();
    apb_write(uer_pkg::REG_SCALE_ADDR, value);
    apb_read_check(uer_pkg::REG_SCALE_ADDR);
    settings_seen++;
  endtask

  initial begin
    int unsigned phase_scale[NUM_PHASES];
    int unsigned start;
    ledger = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_read_check(uer_pkg::REG_SCALE_ADDR);

    // echo low while idle, shortest pulses, then a saturating one at full scale
    send_sample(1'b0);
    send_sample(1'b0);
    send_pulse(1, 0);
    send_pulse(2, 1);
    send_pulse(12, 0);
    set_scale(255);
    send_pulse(TICK_MAX + 5, 0);
    set_scale(1);
    send_pulse(1, 0);
    // zero scale must read as zero
    set_scale(0);
    send_pulse(3, 0);
    settle();
    apb_write(SPARE_ADDR, 32'h0000_00A5);
    apb_read_check(uer_pkg::REG_SCALE_ADDR);

    phase_scale = '{85, 255, 1, $urandom_range(2, 254), $urandom_range(2, 254), 200};
    start = ledger.predicted;
    for (int p = 0; p < NUM_PHASES; p++) begin
      int unsigned first_sample;
      set_scale(phase_scale[p]);
      quiet = (p == 2 || p == 4);
      first_sample = ledger.samples;
      while (ledger.samples - first_sample < RANDOM_ITEMS / NUM_PHASES ||
             (p == NUM_PHASES - 1 && ledger.predicted - start < MIN_RANGES)) begin
        if ($urandom_range(0, 99) < 5) begin
          repeat ($urandom_range(2, 8)) send_sample(1'b0);
        end
        send_pulse(pick_width(), $urandom_range(0, 3));
      end
    end

    quiet = 1'b0;
    settle();
    $display("covered %0d echo samples and %0d distance results over %0d scale settings",
             ledger.samples, ledger.checked, settings_seen + 1);
    $display("%0d mismatches, %0d results still pending",
             ledger.mismatches, ledger.expected_ranges.size());
    if (ledger.mismatches == 0 && ledger.expected_ranges.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the run to complete");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
